/* rtl/modulated_delay_allpass_unit_macros.svh */
// Assertion macros shared by the modulated delay / allpass RTL.
// MAD_ASSERT checks out of reset only; MAD_ASSERT_ALL also checks during reset.
`ifndef MODULATED_DELAY_ALLPASS_UNIT_MACROS_SVH
`define MODULATED_DELAY_ALLPASS_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define MAD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MAD_ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MAD_ASSERT(lbl, clk, rst_n, prop, msg)
`define MAD_ASSERT_ALL(lbl, clk, prop, msg)
`endif

`endif

/* rtl/mad_pkg.sv */
package mad_pkg;

  localparam int unsigned SMP_W      = 24;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned DLEN_W     = 23;
  localparam int unsigned INC_W      = 32;
  localparam int unsigned LFO_DEP_W  = 16;
  localparam int unsigned OFF_W      = 24;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [DLEN_W-1:0] DLEN_RESET = 23'd256;

  localparam logic signed [31:0] SMP_MAX = 32'sd8388607;
  localparam logic signed [31:0] SMP_MIN = -32'sd8388608;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE          = 3'd0,
    CFG_DELAY_LENGTH  = 3'd1,
    CFG_LFO_INCREMENT = 3'd2,
    CFG_LFO_DEPTH     = 3'd3,
    CFG_FEEDBACK_GAIN = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAP,
    ST_RD_NB,
    ST_INTERP,
    ST_MIX,
    ST_WRITE,
    ST_DELIVER
  } unit_state_e;

  typedef enum logic [3:0] {
    TG_IDLE,
    TG_SQUARE,
    TG_DEPTH1,
    TG_DEPTH2,
    TG_SCALE,
    TG_OFFSET,
    TG_REDUCE,
    TG_WHERE,
    TG_DONE
  } tap_state_e;

  typedef struct packed {
    logic interp;
    logic mix;
    logic diffuse;
  } mix_ctrl_t;

  function automatic logic signed [SMP_W-1:0] sat24(input logic signed [31:0] v);
    logic signed [SMP_W-1:0] r;
    if (v > SMP_MAX) begin
      r = SMP_W'(SMP_MAX);
    end else if (v < SMP_MIN) begin
      r = SMP_W'(SMP_MIN);
    end else begin
      r = SMP_W'(v);
    end
    return r;
  endfunction

endpackage

/* rtl/mad_tap_gen.sv */
`include "modulated_delay_allpass_unit_macros.svh"

module mad_tap_gen #(
  parameter int unsigned DEPTH = 32768,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [AW-1:0]                   wp_i,
  input  logic [mad_pkg::INC_W-1:0]       lfo_increment_i,
  input  logic [mad_pkg::LFO_DEP_W-1:0]   lfo_depth_i,
  input  logic [mad_pkg::DLEN_W-1:0]      delay_length_i,
  output logic                            done_o,
  output logic [AW-1:0]                   tap_b_o,
  output logic [AW-1:0]                   tap_nb_o,
  output logic [mad_pkg::FRAC_W-1:0]      frac_o
);
  import mad_pkg::*;

  localparam int unsigned SPAN      = DEPTH * 256;
  localparam int unsigned OFF_LIM   = 1 << OFF_W;
  localparam int unsigned RED_RATIO = (OFF_LIM + SPAN - 1) / SPAN;
  localparam int unsigned RED_STEPS = (RED_RATIO > 1) ? $clog2(RED_RATIO) : 1;
  localparam int unsigned STEP_W    = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
  localparam int unsigned SPAN_W    = $clog2(SPAN + 1);
  localparam int unsigned XW        = ((SPAN_W > OFF_W) ? SPAN_W : OFF_W) + RED_STEPS + 1;

  tap_state_e state_q, state_d;

  logic [INC_W-1:0]        phase_q;
  logic [16:0]             u16_q;
  logic [32:0]             p_q;
  logic [15:0]             m16_q;
  logic [38:0]             dm_q;
  logic [OFF_W-1:0]        rem_q;
  logic [STEP_W-1:0]       step_q;
  logic [AW-1:0]           b_q, nb_q;
  logic [FRAC_W-1:0]       f_q;

  logic signed [15:0]      xs;
  logic signed [31:0]      sq;
  logic [31:0]             u30;
  logic [32:0]             p_d;
  logic [48:0]             m_full;
  logic [38:0]             dm_d;
  logic [XW-1:0]           cmp;
  logic [XW-1:0]           where_raw, where_w;
  logic [AW-1:0]           b_d;

  // Parabola 1 - x^2 from the top half of the phase
  assign xs     = signed'(phase_q[31:16] ^ 16'h8000);
  assign sq     = xs * xs;
  assign u30    = 32'h4000_0000 - unsigned'(sq);
  assign p_d    = 33'(u16_q) * 33'(lfo_depth_i);
  assign m_full = 49'(p_q) * 49'(lfo_depth_i);
  assign dm_d   = 39'(delay_length_i) * 39'(m16_q);
  assign cmp    = XW'(SPAN) << step_q;

  // Read position sits one span ahead, then fold back once
  assign where_raw = XW'({wp_i, 8'b0}) + XW'(SPAN) - XW'(rem_q);
  assign where_w   = (where_raw >= XW'(SPAN)) ? (where_raw - XW'(SPAN)) : where_raw;
  assign b_d       = where_w[AW+7:8];

  always_comb begin
    state_d = state_q;
    case (state_q)
      TG_IDLE:   if (start_i) state_d = TG_SQUARE;
      TG_SQUARE: state_d = TG_DEPTH1;
      TG_DEPTH1: state_d = TG_DEPTH2;
      TG_DEPTH2: state_d = TG_SCALE;
      TG_SCALE:  state_d = TG_OFFSET;
      TG_OFFSET: state_d = TG_REDUCE;
      TG_REDUCE: if (step_q == '0) state_d = TG_WHERE;
      TG_WHERE:  state_d = TG_DONE;
      TG_DONE:   state_d = TG_IDLE;
      default:   state_d = TG_IDLE;
    endcase
  end

  always_comb begin
    done_o = (state_q == TG_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TG_IDLE;
      phase_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == TG_IDLE && start_i) begin
        phase_q <= phase_q + lfo_increment_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      TG_SQUARE: u16_q <= u30[30:14];
      TG_DEPTH1: p_q   <= p_d;
      TG_DEPTH2: m16_q <= m_full[47:32];
      TG_SCALE:  dm_q  <= dm_d;
      TG_OFFSET: begin
        rem_q  <= OFF_W'(delay_length_i) + OFF_W'(256) - OFF_W'(dm_q[38:16]);
        step_q <= STEP_W'(RED_STEPS - 1);
      end
      TG_REDUCE: begin
        // one restoring step per cycle
        if (XW'(rem_q) >= cmp) begin
          rem_q <= OFF_W'(XW'(rem_q) - cmp);
        end
        step_q <= step_q - STEP_W'(1);
      end
      TG_WHERE: begin
        b_q  <= b_d;
        nb_q <= (b_d == AW'(DEPTH - 1)) ? '0 : (b_d + AW'(1));
        f_q  <= where_w[7:0];
      end
      default: ;
    endcase
  end

  assign tap_b_o  = b_q;
  assign tap_nb_o = nb_q;
  assign frac_o   = f_q;

  `MAD_ASSERT(a_start_when_idle, clk_i, rst_ni, start_i |-> state_q == TG_IDLE, "tap start while busy")
  `MAD_ASSERT(a_rem_reduced, clk_i, rst_ni, state_q == TG_WHERE |-> XW'(rem_q) < XW'(SPAN), "read offset not reduced below span")
  `MAD_ASSERT(a_lfo_bound, clk_i, rst_ni, state_q == TG_DEPTH1 |-> u16_q <= 17'd65536, "LFO value above unity")

endmodule

/* rtl/mad_mix.sv */
module mad_mix (
  input  logic                                clk_i,
  input  mad_pkg::mix_ctrl_t                  ctrl_i,
  input  logic signed [mad_pkg::SMP_W-1:0]    sample_i,
  input  logic signed [mad_pkg::GAIN_W-1:0]   gain_i,
  input  logic [mad_pkg::FRAC_W-1:0]          frac_i,
  input  logic signed [mad_pkg::SMP_W-1:0]    tap_b_i,
  input  logic signed [mad_pkg::SMP_W-1:0]    tap_nb_i,
  output logic signed [mad_pkg::SMP_W-1:0]    wval_o,
  output logic signed [mad_pkg::SMP_W-1:0]    res_o
);
  import mad_pkg::*;

  logic signed [9:0]        wb, wn;
  logic signed [33:0]       prod_b, prod_n;
  logic signed [34:0]       acc;
  logic signed [31:0]       gsq_d, gsq_q;
  logic signed [SMP_W-1:0]  smp_q;
  logic signed [39:0]       pg, xg;
  logic signed [25:0]       fb;
  logic signed [31:0]       kq;
  logic signed [55:0]       sk;
  logic signed [56:0]       diff;
  logic signed [SMP_W-1:0]  wval_d, res_d, wval_q, res_q;

  // Linear interpolation between the two neighbouring taps
  assign wb     = signed'({1'b0, 9'd256 - {1'b0, frac_i}});
  assign wn     = signed'({2'b0, frac_i});
  assign prod_b = tap_b_i * wb;
  assign prod_n = tap_nb_i * wn;
  assign acc    = 35'(prod_b) + 35'(prod_n);
  assign gsq_d  = gain_i * gain_i;

  // Allpass terms
  assign pg   = smp_q * gain_i;
  assign fb   = -(26'(sample_i)) - 26'(signed'(pg[39:15]));
  assign xg   = sample_i * gain_i;
  assign kq   = 32'sh4000_0000 - gsq_q;
  assign sk   = smp_q * kq;
  assign diff = 57'(signed'({xg, 15'b0})) - 57'(sk);

  always_comb begin
    if (ctrl_i.diffuse) begin
      wval_d = sat24(32'(fb));
      res_d  = sat24(32'(signed'(diff[56:30])));
    end else begin
      wval_d = sample_i;
      res_d  = smp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.interp) begin
      smp_q <= acc[31:8];
      gsq_q <= gsq_d;
    end
    if (ctrl_i.mix) begin
      wval_q <= wval_d;
      res_q  <= res_d;
    end
  end

  assign wval_o = wval_q;
  assign res_o  = res_q;

endmodule

/* rtl/modulated_delay_allpass_unit.sv */
// LFO-modulated fractional delay line with an allpass diffuser mode.
// Input channel: in_valid_i / in_stall_o carry one signed 24-bit sample a beat.
// Output channel: out_valid_o / out_stall_i return one signed 24-bit sample
// for every input beat, in order.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_addr_i
// (mode, delay length, LFO increment, LFO depth, feedback gain); write only
// while no sample is in flight. Unknown indexes are ignored.
// Flow: one sample at a time. A sample passes the tap generator, the
// neighbour tap read, interpolation, mixing and the store write before its
// result is registered, and the next beat can be taken in the cycle after.
// The tap generator runs an LFO multiplier chain and reduces the read offset
// in 1 step for DEPTH of 32768 and above, up to 14 for DEPTH of 4. The single
// store port takes two reads and one write per sample.
// Reset clears the LFO phase, the write pointer and the registers to their
// defaults; the store reads as zero until each entry is first written, so
// no clearing pass is needed.
// A stalled result holds in the output register; a new input beat is taken
// meanwhile, its result waits in the mix stage until the register is free,
// and the input stalls until then.
`include "modulated_delay_allpass_unit_macros.svh"

module modulated_delay_allpass_unit #(
  parameter int unsigned DEPTH = 32768,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [mad_pkg::SMP_W-1:0]   sample_in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [mad_pkg::SMP_W-1:0]   sample_out_o,
  input  logic                               cfg_we_i,
  input  logic [mad_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input  logic [mad_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import mad_pkg::*;

  unit_state_e state_q, state_d;

  logic                      mode_q;
  logic [DLEN_W-1:0]         dlen_q;
  logic [INC_W-1:0]          inc_q;
  logic [LFO_DEP_W-1:0]      lfo_depth_q;
  logic signed [GAIN_W-1:0]  gain_q;

  logic [AW-1:0]             wp_q;
  logic                      full_q;
  logic signed [SMP_W-1:0]   x_q, s_b_q, s_nb;

  logic [SMP_W-1:0]          store_q [DEPTH];
  logic [SMP_W-1:0]          rdata_q;
  logic                      rd_ok_q, rd_ok_d;
  logic                      mem_en, mem_we;
  logic [AW-1:0]             mem_addr;

  logic                      in_accept, tap_start, tap_done, s_b_load;
  logic [AW-1:0]             tap_b, tap_nb;
  logic [FRAC_W-1:0]         tap_frac;
  mix_ctrl_t                 mix_ctrl;
  logic signed [SMP_W-1:0]   wval, res;

  logic                      out_valid_q, out_load;
  logic signed [SMP_W-1:0]   out_q;

  mad_tap_gen #(
    .DEPTH (DEPTH)
  ) u_tap_gen (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (tap_start),
    .wp_i            (wp_q),
    .lfo_increment_i (inc_q),
    .lfo_depth_i     (lfo_depth_q),
    .delay_length_i  (dlen_q),
    .done_o          (tap_done),
    .tap_b_o         (tap_b),
    .tap_nb_o        (tap_nb),
    .frac_o          (tap_frac)
  );

  mad_mix u_mix (
    .clk_i    (clk_i),
    .ctrl_i   (mix_ctrl),
    .sample_i (x_q),
    .gain_i   (gain_q),
    .frac_i   (tap_frac),
    .tap_b_i  (s_b_q),
    .tap_nb_i (s_nb),
    .wval_o   (wval),
    .res_o    (res)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (in_accept) state_d = ST_TAP;
      ST_TAP:     if (tap_done) state_d = ST_RD_NB;
      ST_RD_NB:   state_d = ST_INTERP;
      ST_INTERP:  state_d = ST_MIX;
      ST_MIX:     state_d = ST_WRITE;
      ST_WRITE:   state_d = ST_DELIVER;
      ST_DELIVER: if (out_load) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o       = (state_q != ST_IDLE);
    in_accept        = in_valid_i && !in_stall_o;
    tap_start        = in_accept;
    mem_en           = 1'b0;
    mem_we           = 1'b0;
    mem_addr         = tap_b;
    s_b_load         = 1'b0;
    out_load         = 1'b0;
    mix_ctrl         = '0;
    mix_ctrl.diffuse = mode_q;
    case (state_q)
      ST_TAP: begin
        mem_en   = tap_done;
        mem_addr = tap_b;
      end
      ST_RD_NB: begin
        mem_en   = 1'b1;
        mem_addr = tap_nb;
        s_b_load = 1'b1;
      end
      ST_INTERP: mix_ctrl.interp = 1'b1;
      ST_MIX:    mix_ctrl.mix = 1'b1;
      ST_WRITE: begin
        mem_en   = 1'b1;
        mem_we   = 1'b1;
        mem_addr = wp_q;
      end
      ST_DELIVER: out_load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  // Entries are written in pointer order from one, so anything past the
  // pointer has never been written until the first wrap
  assign rd_ok_d = full_q || ((mem_addr != '0) && ((mem_addr < wp_q) || (wp_q == '0)));
  assign s_nb    = rd_ok_q ? signed'(rdata_q) : '0;

  always_ff @(posedge clk_i) begin
    if (mem_en && mem_we) begin
      store_q[mem_addr] <= wval;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_en && !mem_we) begin
      rdata_q <= store_q[mem_addr];
      rd_ok_q <= rd_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      x_q <= sample_in_i;
    end
    if (s_b_load) begin
      s_b_q <= rd_ok_q ? signed'(rdata_q) : '0;
    end
    if (out_load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : (wp_q + AW'(1));
      end
      if (state_q == ST_WRITE && wp_q == '0) begin
        full_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      dlen_q      <= DLEN_RESET;
      inc_q       <= '0;
      lfo_depth_q <= '0;
      gain_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_MODE:          mode_q      <= cfg_wdata_i[0];
        CFG_DELAY_LENGTH:  dlen_q      <= cfg_wdata_i[DLEN_W-1:0];
        CFG_LFO_INCREMENT: inc_q       <= cfg_wdata_i[INC_W-1:0];
        CFG_LFO_DEPTH:     lfo_depth_q <= cfg_wdata_i[LFO_DEP_W-1:0];
        CFG_FEEDBACK_GAIN: gain_q      <= signed'(cfg_wdata_i[GAIN_W-1:0]);
        default: ;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

  `MAD_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o,
              "input taken while a sample is in flight")
  `MAD_ASSERT(a_tap_done_in_tap, clk_i, rst_ni, tap_done |-> state_q == ST_TAP,
              "tap result outside the tap wait")
  `MAD_ASSERT(a_full_sticky, clk_i, rst_ni, full_q |=> full_q, "store full flag dropped")
  `MAD_ASSERT_ALL(a_reset_idle, clk_i, !rst_ni |=> state_q == ST_IDLE && !out_valid_q,
                  "not idle in reset")

endmodule
